FILE: hw/rtl/lol_pkg.sv
// ----------------------------------------------------------------------------
// lol_pkg
// Shared types and constants for the LRU order list.
// ----------------------------------------------------------------------------
package lol_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NO_SLOT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_APPLY
    } t_state;

    // per-cell move controls; load wins over shift
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    // free-slot search works on groups of this many slots
    localparam int GROUP_BITS  = 32;
    localparam int GROUP_IDX_W = 5;

endpackage

FILE: hw/rtl/lol_chan_if.sv
// ----------------------------------------------------------------------------
// lol_chan_if
// Valid/ready channel with a flat payload vector.
// ----------------------------------------------------------------------------
interface lol_chan_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/lru_order_list_top.sv
// ----------------------------------------------------------------------------
// lru_order_list_top
// LRU recency list over a fixed slot pool, kept as a shifting row of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of SLOTS cells, oldest entry in cell 0 and newest in
// cell count-1; pop, update and delete move cells by one position toward cell
// 0, and push loads the new entry into cell count. One operation is taken at a
// time and runs these steps after the request transfer: compare every cell
// against the slot handle (S_SCAN), encode the hit position and select its data
// (S_PICK), and move the cells once the response register is free (S_APPLY),
// while the lowest free slot comes out of a two-level registered search of the
// in-use bits alongside. The next request is taken in the cycle after the result
// is registered. A new request is taken while the previous result still waits
// on the response channel; the block stalls only when a second result would
// overwrite an untaken one. No clearing pass is needed after reset. Request
// payload: op[1:0], slot, slot_valid, data (LSB first); response payload:
// status[1:0], out_slot, out_data, count.
// ----------------------------------------------------------------------------
module lru_order_list_top #(
    parameter int SLOTS     = 64,
    parameter int DATA_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lol_chan_if.sink   i_req,
    lol_chan_if.source o_rsp
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // request layout
    localparam int RQ_SLOT  = 2;
    localparam int RQ_VALID = RQ_SLOT + SLOT_W;
    localparam int RQ_DATA  = RQ_VALID + 1;
    // response layout
    localparam int RS_SLOT  = 2;
    localparam int RS_DATA  = RS_SLOT + SLOT_W;
    localparam int RS_CNT   = RS_DATA + DATA_BITS;

    lol_pkg::t_state       r_state, n_state;
    lol_pkg::t_op          r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_slot_valid;
    logic [DATA_BITS-1:0]  r_data;

    logic [CNT_W-1:0]      r_count;
    logic [SLOTS-1:0]      r_in_use;

    logic [SLOTS-1:0]      r_hit_vec;
    logic [SLOT_W-1:0]     r_hit_pos, n_hit_pos;
    logic [DATA_BITS-1:0]  r_hit_data, n_hit_data;

    logic                  r_rsp_valid;
    lol_pkg::t_status      r_rsp_status;
    logic [SLOT_W-1:0]     r_rsp_slot;
    logic [DATA_BITS-1:0]  r_rsp_data;
    logic [CNT_W-1:0]      r_rsp_count;

    logic                  w_accept;
    logic                  w_apply;
    logic                  w_free_any;
    logic [SLOT_W-1:0]     w_free_idx;
    logic                  w_in_range;
    logic                  w_known;
    logic                  w_push, w_pop, w_upd, w_del;
    lol_pkg::t_status      w_status;
    logic [CNT_W-1:0]      w_count_next;

    lol_pkg::t_cell_ctl    w_ctl       [SLOTS];
    logic [SLOTS-1:0]      w_hit;
    logic [SLOT_W-1:0]     w_cell_slot [SLOTS];
    logic [DATA_BITS-1:0]  w_cell_data [SLOTS];
    logic [SLOT_W-1:0]     w_load_slot;
    logic [DATA_BITS-1:0]  w_load_data;

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lol_pkg::S_IDLE:  if (w_accept) n_state = lol_pkg::S_SCAN;
            lol_pkg::S_SCAN:  n_state = lol_pkg::S_PICK;
            lol_pkg::S_PICK:  n_state = lol_pkg::S_APPLY;
            lol_pkg::S_APPLY: if (w_apply) n_state = lol_pkg::S_IDLE;
            default:          n_state = lol_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == lol_pkg::S_IDLE);
        w_accept    = i_req.valid && (r_state == lol_pkg::S_IDLE);
        w_apply     = (r_state == lol_pkg::S_APPLY) && (!r_rsp_valid || o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lol_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= lol_pkg::t_op'(i_req.payload[1:0]);
            r_slot       <= i_req.payload[RQ_SLOT +: SLOT_W];
            r_slot_valid <= i_req.payload[RQ_VALID];
            r_data       <= i_req.payload[RQ_DATA +: DATA_BITS];
        end
    end

    // ---------------- decode ----------------
    assign w_in_range = ({1'b0, r_slot} < (SLOT_W + 1)'(SLOTS));

    always_comb begin
        w_known  = w_in_range ? r_in_use[r_slot] : 1'b0;
        w_push   = (r_op == lol_pkg::OP_PUSH) && w_free_any;
        w_pop    = (r_op == lol_pkg::OP_POP) && (r_count != '0);
        w_upd    = (r_op == lol_pkg::OP_UPDATE) && r_slot_valid && w_known;
        w_del    = (r_op == lol_pkg::OP_DELETE) && r_slot_valid && w_known;
        w_status = lol_pkg::ST_OK;
        case (r_op)
            lol_pkg::OP_PUSH: if (!w_free_any) w_status = lol_pkg::ST_FULL;
            lol_pkg::OP_POP:  if (r_count == '0) w_status = lol_pkg::ST_EMPTY;
            default:          if (r_slot_valid && !w_known) w_status = lol_pkg::ST_NO_SLOT;
        endcase
        w_count_next = r_count;
        if (w_push) begin
            w_count_next = r_count + CNT_W'(1);
        end else if (w_pop || w_del) begin
            w_count_next = r_count - CNT_W'(1);
        end
    end

    // ---------------- free slot search ----------------
    lol_free_find #(
        .SLOTS (SLOTS),
        .IDX_W (SLOT_W)
    ) u_free_find (
        .i_clk    (i_clk),
        .i_in_use (r_in_use),
        .o_any    (w_free_any),
        .o_idx    (w_free_idx)
    );

    // ---------------- cell row ----------------
    assign w_load_slot = w_push ? w_free_idx : r_slot;
    assign w_load_data = w_push ? r_data : r_hit_data;

    for (genvar j = 0; j < SLOTS; j++) begin : g_cell
        logic [SLOT_W-1:0]    w_next_slot;
        logic [DATA_BITS-1:0] w_next_data;

        if (j == SLOTS - 1) begin : g_end
            assign w_next_slot = '0;
            assign w_next_data = '0;
        end else begin : g_mid
            assign w_next_slot = w_cell_slot[j+1];
            assign w_next_data = w_cell_data[j+1];
        end

        // update moves the hit entry to the newest end; cells above it close up
        assign w_ctl[j].load  = w_apply &&
            ((w_push && (CNT_W'(j) == r_count)) ||
             (w_upd  && (CNT_W'(j) == r_count - CNT_W'(1))));
        assign w_ctl[j].shift = w_apply &&
            (w_pop || ((w_upd || w_del) && (SLOT_W'(j) >= r_hit_pos)));

        lol_cell #(
            .SLOT_W    (SLOT_W),
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[j]),
            .i_occ       (CNT_W'(j) < r_count),
            .i_key       (r_slot),
            .i_next_slot (w_next_slot),
            .i_next_data (w_next_data),
            .i_load_slot (w_load_slot),
            .i_load_data (w_load_data),
            .o_hit       (w_hit[j]),
            .o_slot      (w_cell_slot[j]),
            .o_data      (w_cell_data[j])
        );
    end

    // hit position and data; at most one cell matches
    always_comb begin
        n_hit_pos  = '0;
        n_hit_data = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (r_hit_vec[j]) begin
                n_hit_pos  = n_hit_pos | SLOT_W'(j);
                n_hit_data = n_hit_data | w_cell_data[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_vec  <= w_hit;
        r_hit_pos  <= n_hit_pos;
        r_hit_data <= n_hit_data;
    end

    // ---------------- list state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_in_use <= '0;
        end else if (w_apply) begin
            r_count <= w_count_next;
            if (w_push) begin
                r_in_use[w_free_idx] <= 1'b1;
            end else if (w_pop) begin
                r_in_use[w_cell_slot[0]] <= 1'b0;
            end else if (w_del) begin
                r_in_use[r_slot] <= 1'b0;
            end
        end
    end

    // ---------------- response ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_apply) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_rsp_status <= w_status;
            r_rsp_slot   <= w_push ? w_free_idx : (w_pop ? w_cell_slot[0] : '0);
            r_rsp_data   <= w_pop ? w_cell_data[0] : '0;
            r_rsp_count  <= w_count_next;
        end
    end

    assign o_rsp.valid                         = r_rsp_valid;
    assign o_rsp.payload[1:0]                  = r_rsp_status;
    assign o_rsp.payload[RS_SLOT +: SLOT_W]    = r_rsp_slot;
    assign o_rsp.payload[RS_DATA +: DATA_BITS] = r_rsp_data;
    assign o_rsp.payload[RS_CNT +: CNT_W]      = r_rsp_count;

endmodule

FILE: hw/rtl/lol_cell.sv
// ----------------------------------------------------------------------------
// lol_cell
// One position of the recency chain: holds a slot index and its data word.
// ----------------------------------------------------------------------------
module lol_cell #(
    parameter int SLOT_W    = 6,
    parameter int DATA_BITS = 32
) (
    input  logic                  i_clk,
    input  lol_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occ,
    input  logic [SLOT_W-1:0]     i_key,
    input  logic [SLOT_W-1:0]     i_next_slot,
    input  logic [DATA_BITS-1:0]  i_next_data,
    input  logic [SLOT_W-1:0]     i_load_slot,
    input  logic [DATA_BITS-1:0]  i_load_data,
    output logic                  o_hit,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [DATA_BITS-1:0]  o_data
);

    logic [SLOT_W-1:0]    r_slot;
    logic [DATA_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_slot <= i_load_slot;
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_slot <= i_next_slot;
            r_data <= i_next_data;
        end
    end

    assign o_hit  = i_occ && (r_slot == i_key);
    assign o_slot = r_slot;
    assign o_data = r_data;

endmodule

FILE: hw/rtl/lol_free_find.sv
// ----------------------------------------------------------------------------
// lol_free_find
// Two-level registered search for the lowest-numbered free slot.
// ----------------------------------------------------------------------------
module lol_free_find #(
    parameter int SLOTS = 64,
    parameter int IDX_W = 6
) (
    input  logic              i_clk,
    input  logic [SLOTS-1:0]  i_in_use,
    output logic              o_any,
    output logic [IDX_W-1:0]  o_idx
);

    localparam int GROUPS = (SLOTS + lol_pkg::GROUP_BITS - 1) / lol_pkg::GROUP_BITS;
    localparam int PAD    = GROUPS * lol_pkg::GROUP_BITS;

    logic [PAD-1:0]                    w_used;
    logic [GROUPS-1:0]                 n_grp_any;
    logic [lol_pkg::GROUP_IDX_W-1:0]   n_grp_idx [GROUPS];
    logic [GROUPS-1:0]                 r_grp_any;
    logic [lol_pkg::GROUP_IDX_W-1:0]   r_grp_idx [GROUPS];
    logic                              n_any;
    logic [IDX_W-1:0]                  n_idx;
    logic                              r_any;
    logic [IDX_W-1:0]                  r_idx;

    // slots past the pool count as used
    always_comb begin
        w_used              = '1;
        w_used[SLOTS-1:0]   = i_in_use;
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp_any[g] = ~&w_used[g*lol_pkg::GROUP_BITS +: lol_pkg::GROUP_BITS];
            n_grp_idx[g] = '0;
            for (int b = lol_pkg::GROUP_BITS - 1; b >= 0; b--) begin
                if (!w_used[g*lol_pkg::GROUP_BITS + b]) begin
                    n_grp_idx[g] = lol_pkg::GROUP_IDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= n_grp_any;
        for (int g = 0; g < GROUPS; g++) begin
            r_grp_idx[g] <= n_grp_idx[g];
        end
    end

    always_comb begin
        n_any = |r_grp_any;
        n_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                n_idx = IDX_W'(g * lol_pkg::GROUP_BITS + int'(r_grp_idx[g]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= n_any;
        r_idx <= n_idx;
    end

    assign o_any = r_any;
    assign o_idx = r_idx;

endmodule
